/* rtl/core/dndt_pkg.sv */
// ----------------------------------------------------------------------------
// dndt_pkg
// Shared constants, month-length table and the control/status bundles used
// between the day-number-to-date controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dndt_pkg;

  localparam int DAY_NUMBER_W = 31;
  localparam int YEAR_W       = 23;
  localparam int MONTH_W      = 4;
  localparam int DAY_W        = 5;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 32;

  // 400-year cycle
  localparam logic [DAY_NUMBER_W-1:0] CYCLE_DAYS  = 31'd146097;
  localparam logic [YEAR_W-1:0]       CYCLE_YEARS = 23'd400;

  // quotient of a 31-bit count by CYCLE_DAYS fits in 14 bits
  localparam int CYC_Q_W = 14;

  // ceil(2^49 / CYCLE_DAYS); exact quotient for every 31-bit count
  localparam int                RECIP_W      = 32;
  localparam int                RECIP_PROD_W = DAY_NUMBER_W + RECIP_W;
  localparam int                RECIP_SHIFT  = 49;
  localparam logic [RECIP_W-1:0] CYCLE_RECIP = 32'd3853261556;

  localparam int YC_W   = 9;   // year within cycle, 0..400
  localparam int C100_W = 7;   // year mod 100

  localparam logic [YC_W-1:0]   YC_CYCLE_END = 9'd400;
  localparam logic [C100_W-1:0] C100_LAST    = 7'd99;
  localparam logic [8:0]        YEAR_DAYS    = 9'd365;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // days in month, non-leap
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                      d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  typedef struct packed {
    logic load;        // capture accepted beat, start conversion
    logic div_step;    // one cycle-division phase
    logic year_step;   // take one year off
    logic month_step;  // take one month off
    logic out_load;    // latch finished result into output register
  } dndt_cmd_t;

  typedef struct packed {
    logic div_last;    // final division phase this cycle
    logic year_done;   // remainder lies inside current year
    logic month_done;  // remainder lies inside current month
  } dndt_status_t;

endpackage

`default_nettype wire

/* rtl/core/dndt_ctrl.sv */
// ----------------------------------------------------------------------------
// dndt_ctrl
// Sequencer: accept, cycle division, year walk, month walk, hand-off to the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dndt_ctrl
  import dndt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire dndt_status_t status,
  output dndt_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_YEAR  = 2'd2;
  localparam logic [1:0] ST_MONTH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_valid_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (status.year_done) begin
          state_next = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (!status.month_done) begin
          cmd.month_step = 1'b1;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dndt_dp.sv */
// ----------------------------------------------------------------------------
// dndt_dp
// Datapath: division by the 400-year cycle through a reciprocal multiply,
// year and month subtract loops, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dndt_dp
  import dndt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic [DAY_NUMBER_W-1:0] day_number,
  input  wire dndt_cmd_t               cmd,
  output dndt_status_t                 status,
  output logic [YEAR_W-1:0]            year,
  output logic [MONTH_W-1:0]           month,
  output logic [DAY_W-1:0]             day_of_month
);

  logic [DAY_NUMBER_W-1:0] rem;
  logic [YEAR_W-1:0]       year_base;
  logic                    div_phase;   // 0: quotient, 1: remainder
  logic [CYC_Q_W-1:0]      cyc_q;
  logic [YC_W-1:0]         yc;
  logic [1:0]              c4;
  logic [C100_W-1:0]       c100;
  logic [MONTH_W-1:0]      mon;

  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [DAY_NUMBER_W-1:0] cyc_days;
  logic [YEAR_W-1:0]       cyc_years;
  logic                    leap;
  logic [8:0]              year_len;
  logic [DAY_W-1:0]        month_len;

  // whole cycles: multiply by the rounded-up reciprocal, keep the top bits
  assign recip_prod = {{(RECIP_PROD_W-DAY_NUMBER_W){1'b0}}, rem}
                    * {{(RECIP_PROD_W-RECIP_W){1'b0}}, CYCLE_RECIP};
  assign cyc_days   = {{(DAY_NUMBER_W-CYC_Q_W){1'b0}}, cyc_q} * CYCLE_DAYS;
  assign cyc_years  = {{(YEAR_W-CYC_Q_W){1'b0}}, cyc_q} * CYCLE_YEARS;

  // leap test on year within cycle; cycle start is a multiple of 400
  assign leap     = ((c4 == 2'd0) && (c100 != '0)) || (yc == '0) || (yc == YC_CYCLE_END);
  assign year_len = YEAR_DAYS + {8'd0, leap};
  assign month_len = month_days(mon) + {4'd0, (mon == MONTH_FEB) && leap};

  assign status.div_last   = div_phase;
  assign status.year_done  = (yc == YC_CYCLE_END) || (rem < {22'd0, year_len});
  assign status.month_done = (mon == MONTH_DEC) || (rem < {26'd0, month_len});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem       <= day_number;
      year_base <= '0;
      div_phase <= 1'b0;
      yc        <= '0;
      c4        <= '0;
      c100      <= '0;
      mon       <= MONTH_JAN;
    end else if (cmd.div_step) begin
      if (!div_phase) begin
        cyc_q <= recip_prod[RECIP_SHIFT +: CYC_Q_W];
      end else begin
        rem       <= rem - cyc_days;
        year_base <= cyc_years;
      end
      div_phase <= 1'b1;
    end else if (cmd.year_step) begin
      rem  <= rem - {22'd0, year_len};
      yc   <= yc + 1'b1;
      c4   <= c4 + 1'b1;
      c100 <= (c100 == C100_LAST) ? '0 : c100 + 1'b1;
    end else if (cmd.month_step) begin
      rem <= rem - {26'd0, month_len};
      mon <= mon + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      year         <= year_base + {14'd0, yc};
      month        <= mon;
      day_of_month <= rem[DAY_W-1:0] + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/day_number_to_date.sv */
// Sequence: accept, division (quotient, then remainder), year walk, month
//   walk, then the load into the output register once it is free.
// Throughput: one beat at a time; the year walk (one year per cycle) sets
//   the figure. The next beat is taken while a result waits on the master side.
// Reset: rst is synchronous, active high; clears the sequencer and the
//   output valid flag. No stored tables to clear.
// ----------------------------------------------------------------------------
// day_number_to_date
// Converts a day count from January 1 of year 0 into proleptic Gregorian
// year, month and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module day_number_to_date
  import dndt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // slave side
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [30:0] day_number, [31] pad
  // master side
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata    // [22:0] year, [26:23] month,
                                                 // [31:27] day_of_month
);

  dndt_cmd_t          cmd;
  dndt_status_t       status;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day_of_month;

  // sequencer: owns handshakes and output valid
  dndt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic: cycle division, year and month walks, result register
  dndt_dp u_dp (
    .clk          (clk),
    .day_number   (s_tdata[DAY_NUMBER_W-1:0]),
    .cmd          (cmd),
    .status       (status),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month)
  );

  assign m_tdata = {day_of_month, month, year};

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------

  // s_tready drops once a beat is accepted: no second accept right after one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while conversion running");

  // month walk never leaves 1..12
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (month >= MONTH_JAN) && (month <= MONTH_DEC))
    else $error("month out of range");

  // day of month never wraps to zero
  a_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (day_of_month != '0))
    else $error("day of month is zero");

  // a fresh result cannot show up the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!m_tvalid || $past(m_tvalid)))
    else $error("result appeared too early");

endmodule

`default_nettype wire

/* dv/tb_day_number_to_date.sv */
// ----------------------------------------------------------------------------
// tb_day_number_to_date
// Self-checking bench for the day-number-to-date converter. A local calendar
// predictor works out year, month and day for every accepted beat. A monitor
// compares each output beat against the oldest pending date. Phases cover
// corner dates, random streams under sender gaps and receiver stalls, and a
// long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_day_number_to_date;
  import dndt_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  // Settle time after the queue drains, past the worst case for one beat.
  localparam int SETTLE_CYCLES = 500;
  // Long enough for one result to park at the output and a second to finish
  // behind it, so s_tready has to drop while we keep offering beats.
  localparam int HOLD_CYCLES   = 2000;
  // Bound on the whole run: every beat at its slowest plus the hold-off;
  // allow several times that before giving up.
  localparam longint LIMIT_CYCLES = 3_000_000;

  localparam int unsigned LAST_SAFE_YEAR = 5_879_000;   // Jan 1 + 365 still fits
  localparam int unsigned LAST_CYCLE     = 14_699;      // whole cycles in 31 bits

  // Plain-year month lengths; February is patched for leap years.
  localparam int unsigned DAYS_IN_MONTH [12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Year 0 is leap. Year 100 starts at day 36525 and is not leap; year 400 is.
  localparam logic [IN_TDATA_W-1:0] CORNER_DAYS [20] = '{
    32'd0,              // Jan 1 of year 0
    32'd30,             // Jan 31
    32'd31,             // Feb 1
    32'd59,             // Feb 29 of a leap year
    32'd60,             // Mar 1 of a leap year
    32'd335,            // Dec 1
    32'd365,            // Dec 31 of a leap year
    32'd366,            // Jan 1 of year 1
    32'd1520,           // Feb 29 of year 4
    32'd36524,          // Dec 31 of year 99
    32'd36583,          // Feb 28 of year 100, century without leap day
    32'd36584,          // Mar 1 of year 100
    32'd146096,         // last day of the first 400-year cycle
    32'd146097,         // first day of year 400
    32'd146156,         // Feb 29 of year 400, century leap year
    32'd1_000_000,
    32'h7FFF_FFFE,
    32'h7FFF_FFFF,      // largest day number, largest year
    32'h8000_0000,      // pad bit set, day number zero
    32'hFFFF_FFFF       // pad bit set over the largest day number
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
  } date_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;      // [30:0] day_number, [31] pad
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;            // [22:0] year, [26:23] month,
                                              // [31:27] day_of_month

  date_t pending_dates [$];
  int    mismatch_count = 0;

  // Percent chance per cycle of a sender gap / a receiver stall.
  int unsigned sender_gap_pct  = 0;
  int unsigned recv_stall_pct  = 0;

  // Hold-off requests are counted so that only the receiver process owns
  // its down-counter.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  day_number_to_date dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned leap_year(input int unsigned y);
    return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 1 : 0;
  endfunction

  function automatic date_t predict_date(input logic [DAY_NUMBER_W-1:0] days);
    int unsigned cycles;
    int unsigned rem;
    int unsigned yc;
    int unsigned mon;
    int unsigned len;
    int unsigned leap;
    date_t       d;
    cycles = int'(days) / int'(CYCLE_DAYS);
    rem    = int'(days) % int'(CYCLE_DAYS);
    yc     = 0;
    // Leap test on the year within the cycle matches the full-year test,
    // since every cycle starts on a multiple of 400.
    while (yc < int'(CYCLE_YEARS) && rem >= int'(YEAR_DAYS) + leap_year(yc)) begin
      rem -= int'(YEAR_DAYS) + leap_year(yc);
      yc++;
    end
    leap = leap_year(yc);
    mon  = 1;
    while (mon < 12) begin
      len = DAYS_IN_MONTH[mon-1] + ((mon == 2) ? leap : 0);
      if (rem < len) break;
      rem -= len;
      mon++;
    end
    d.year         = YEAR_W'(cycles * int'(CYCLE_YEARS) + yc);
    d.month        = MONTH_W'(mon);
    d.day_of_month = DAY_W'(rem + 1);
    return d;
  endfunction

  // Day number of Jan 1 of year y (year 0 is leap).
  function automatic longint unsigned first_day_of_year(input longint unsigned y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  // Mix of plain random counts and counts aimed at year, century and cycle
  // boundaries, plus the very top of the range. The pad bit is random.
  function automatic logic [IN_TDATA_W-1:0] random_day_word();
    longint unsigned n;
    longint unsigned y;
    case ($urandom_range(0, 9))
      0, 1, 2: n = $urandom() & 32'h7FFF_FFFF;
      3, 4:    n = $urandom_range(0, 3 * int'(CYCLE_DAYS));
      5, 6: begin
        y = $urandom_range(0, LAST_SAFE_YEAR);
        n = first_day_of_year(y) + $urandom_range(0, 365);
      end
      7: begin
        // just before a century start, leap or not
        y = longint'($urandom_range(1, LAST_SAFE_YEAR / 100)) * 100;
        n = first_day_of_year(y) - $urandom_range(1, 3);
      end
      8:       n = 32'h7FFF_FFFF - $urandom_range(0, 2000);
      default: begin
        n = longint'($urandom_range(1, LAST_CYCLE)) * int'(CYCLE_DAYS);
        n = n - 2 + $urandom_range(0, 4);
      end
    endcase
    return {1'($urandom_range(0, 1)), DAY_NUMBER_W'(n)};
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Entered right after an edge; leaves right after the accepting edge with
  // s_tvalid still high, so back-to-back beats never toggle it.
  task automatic send_day(input logic [IN_TDATA_W-1:0] word);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    pending_dates.push_back(predict_date(word[DAY_NUMBER_W-1:0]));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_days(input int count);
    repeat (count) send_day(random_day_word());
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, plus a counted long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    date_t want;
    date_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.year         = m_tdata[YEAR_W-1:0];
      got.month        = m_tdata[YEAR_W +: MONTH_W];
      got.day_of_month = m_tdata[YEAR_W+MONTH_W +: DAY_W];
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected beat: year %0d month %0d day %0d", $time,
                 got.year, got.month, got.day_of_month);
      end else begin
        want = pending_dates.pop_front();
        if (got.year != want.year) begin
          mismatch_count++;
          $display("%0t year: expected %0d, got %0d", $time, want.year, got.year);
        end
        if (got.month != want.month) begin
          mismatch_count++;
          $display("%0t month: expected %0d, got %0d", $time, want.month, got.month);
        end
        if (got.day_of_month != want.day_of_month) begin
          mismatch_count++;
          $display("%0t day_of_month: expected %0d, got %0d", $time,
                   want.day_of_month, got.day_of_month);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_corner_dates();
    sender_gap_pct = 0;
    recv_stall_pct <= 0;
    foreach (CORNER_DAYS[i]) send_day(CORNER_DAYS[i]);
    wait_drained();
  endtask

  task automatic test_streaming();
    sender_gap_pct = 0;
    recv_stall_pct <= 0;
    send_random_days(220);
  endtask

  task automatic test_sender_gaps();
    sender_gap_pct = 61;
    recv_stall_pct <= 0;
    send_random_days(220);
  endtask

  task automatic test_receiver_stalls();
    sender_gap_pct = 0;
    recv_stall_pct <= 61;
    send_random_days(220);
  endtask

  task automatic test_mixed_idling();
    sender_gap_pct = 13;
    recv_stall_pct <= 13;
    send_random_days(220);
  endtask

  // Output held off for a long stretch while beats keep coming: the output
  // register fills, the next conversion finishes behind it and s_tready drops.
  // Then the sender pauses until every date has come back.
  task automatic test_backpressure();
    sender_gap_pct = 0;
    recv_stall_pct <= 0;
    hold_requests  <= hold_requests + 1;
    send_random_days(8);
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_dates();
    test_streaming();
    test_sender_gaps();
    test_backpressure();
    test_receiver_stalls();
    test_mixed_idling();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
